[rtl/sit_pkg.sv]
// Shared widths, stage payload types and helpers for the segment intersection test pipeline.
package sit_pkg;

    localparam int IN_BITS    = 32;
    localparam int COORD_BITS = 32;
    localparam int DIFF_BITS  = COORD_BITS + 1;
    localparam int PROD_BITS  = 2 * DIFF_BITS;
    localparam int CROSS_BITS = PROD_BITS + 1;
    localparam int TURNS      = 4;

    typedef logic signed [IN_BITS-1:0]    in_coord_t;
    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic signed [DIFF_BITS-1:0]  diff_t;
    typedef logic        [DIFF_BITS-1:0]  mag_t;
    typedef logic signed [PROD_BITS-1:0]  prod_t;
    typedef logic signed [CROSS_BITS-1:0] cross_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
    } point_t;

    // Stage 1: edge vectors, bounding boxes and endpoint equality.
    typedef struct packed {
        diff_t  d12x;
        diff_t  d12y;
        diff_t  d13x;
        diff_t  d13y;
        diff_t  d14x;
        diff_t  d14y;
        diff_t  d34x;
        diff_t  d34y;
        diff_t  d31x;
        diff_t  d31y;
        diff_t  d32x;
        diff_t  d32y;
        coord_t x12_lo;
        coord_t x12_hi;
        coord_t y12_lo;
        coord_t y12_hi;
        coord_t x34_lo;
        coord_t x34_hi;
        coord_t y34_lo;
        coord_t y34_hi;
        point_t p1;
        point_t p2;
        point_t p3;
        point_t p4;
        logic   shared;
        logic   ignore_shared;
    } s1_t;

    // Stage 2: the two products of each cross product, plus the range tests.
    typedef struct packed {
        prod_t [TURNS-1:0] lhs;
        prod_t [TURNS-1:0] rhs;
        logic              use_x;
        logic              over_x;
        logic              over_y;
        logic [TURNS-1:0]  in_box;
        logic              shared;
        logic              ignore_shared;
    } s2_t;

    // Stage 3: orientation signs.
    typedef struct packed {
        logic [TURNS-1:0] neg;
        logic [TURNS-1:0] zero;
        logic             use_x;
        logic             over_x;
        logic             over_y;
        logic [TURNS-1:0] in_box;
        logic             shared;
        logic             ignore_shared;
    } s3_t;

    function automatic coord_t to_coord(input logic [IN_BITS-1:0] raw);
        logic [63:0] ext;
        ext = {{(64 - IN_BITS){raw[IN_BITS-1]}}, raw};
        return coord_t'(ext[COORD_BITS-1:0]);
    endfunction

    function automatic diff_t sub_coord(input coord_t a, input coord_t b);
        return DIFF_BITS'(a) - DIFF_BITS'(b);
    endfunction

    function automatic mag_t mag_of(input diff_t d);
        return d[DIFF_BITS-1] ? mag_t'(-d) : mag_t'(d);
    endfunction

endpackage

[rtl/sit_diff_stage.sv]
// Stage 1: coordinate differences, bounding boxes and shared endpoint detection.
module sit_diff_stage (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  sit_pkg::point_t    p1,
    input  sit_pkg::point_t    p2,
    input  sit_pkg::point_t    p3,
    input  sit_pkg::point_t    p4,
    input  logic               ignore_shared,
    output logic               out_valid,
    input  logic               out_ready,
    output sit_pkg::s1_t       out_data
);
    import sit_pkg::*;

    logic valid_reg;
    s1_t  data_reg;
    s1_t  data_next;

    always_comb begin
        data_next.d12x = sub_coord(p2.x, p1.x);
        data_next.d12y = sub_coord(p2.y, p1.y);
        data_next.d13x = sub_coord(p3.x, p1.x);
        data_next.d13y = sub_coord(p3.y, p1.y);
        data_next.d14x = sub_coord(p4.x, p1.x);
        data_next.d14y = sub_coord(p4.y, p1.y);
        data_next.d34x = sub_coord(p4.x, p3.x);
        data_next.d34y = sub_coord(p4.y, p3.y);
        data_next.d31x = sub_coord(p1.x, p3.x);
        data_next.d31y = sub_coord(p1.y, p3.y);
        data_next.d32x = sub_coord(p2.x, p3.x);
        data_next.d32y = sub_coord(p2.y, p3.y);

        data_next.x12_lo = (p1.x < p2.x) ? p1.x : p2.x;
        data_next.x12_hi = (p1.x < p2.x) ? p2.x : p1.x;
        data_next.y12_lo = (p1.y < p2.y) ? p1.y : p2.y;
        data_next.y12_hi = (p1.y < p2.y) ? p2.y : p1.y;
        data_next.x34_lo = (p3.x < p4.x) ? p3.x : p4.x;
        data_next.x34_hi = (p3.x < p4.x) ? p4.x : p3.x;
        data_next.y34_lo = (p3.y < p4.y) ? p3.y : p4.y;
        data_next.y34_hi = (p3.y < p4.y) ? p4.y : p3.y;

        data_next.p1 = p1;
        data_next.p2 = p2;
        data_next.p3 = p3;
        data_next.p4 = p4;

        data_next.shared = (p1 == p3) || (p1 == p4) || (p2 == p3) || (p2 == p4);
        data_next.ignore_shared = ignore_shared;
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            data_reg <= data_next;
        end
    end

endmodule

[rtl/sit_mul_stage.sv]
// Stage 2: cross product partial products, dominant axis, overlap and box tests.
module sit_mul_stage (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  sit_pkg::s1_t    in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output sit_pkg::s2_t    out_data
);
    import sit_pkg::*;

    logic valid_reg;
    s2_t  data_reg;
    s2_t  data_next;

    // Positive overlap of [alo,ahi] and [clo,chi]: min of highs above max of lows.
    function automatic logic overlaps(input coord_t alo, input coord_t ahi,
                                      input coord_t clo, input coord_t chi);
        return (ahi > alo) && (ahi > clo) && (chi > alo) && (chi > clo);
    endfunction

    function automatic logic boxed(input point_t p, input coord_t xlo, input coord_t xhi,
                                   input coord_t ylo, input coord_t yhi);
        return (p.x >= xlo) && (p.x <= xhi) && (p.y >= ylo) && (p.y <= yhi);
    endfunction

    always_comb begin
        data_next.lhs[0] = $signed(in_data.d12x) * $signed(in_data.d13y);
        data_next.rhs[0] = $signed(in_data.d12y) * $signed(in_data.d13x);
        data_next.lhs[1] = $signed(in_data.d12x) * $signed(in_data.d14y);
        data_next.rhs[1] = $signed(in_data.d12y) * $signed(in_data.d14x);
        data_next.lhs[2] = $signed(in_data.d34x) * $signed(in_data.d31y);
        data_next.rhs[2] = $signed(in_data.d34y) * $signed(in_data.d31x);
        data_next.lhs[3] = $signed(in_data.d34x) * $signed(in_data.d32y);
        data_next.rhs[3] = $signed(in_data.d34y) * $signed(in_data.d32x);

        data_next.use_x  = mag_of(in_data.d12x) >= mag_of(in_data.d12y);
        data_next.over_x = overlaps(in_data.x12_lo, in_data.x12_hi,
                                    in_data.x34_lo, in_data.x34_hi);
        data_next.over_y = overlaps(in_data.y12_lo, in_data.y12_hi,
                                    in_data.y34_lo, in_data.y34_hi);

        data_next.in_box[0] = boxed(in_data.p3, in_data.x12_lo, in_data.x12_hi,
                                    in_data.y12_lo, in_data.y12_hi);
        data_next.in_box[1] = boxed(in_data.p4, in_data.x12_lo, in_data.x12_hi,
                                    in_data.y12_lo, in_data.y12_hi);
        data_next.in_box[2] = boxed(in_data.p1, in_data.x34_lo, in_data.x34_hi,
                                    in_data.y34_lo, in_data.y34_hi);
        data_next.in_box[3] = boxed(in_data.p2, in_data.x34_lo, in_data.x34_hi,
                                    in_data.y34_lo, in_data.y34_hi);

        data_next.shared        = in_data.shared;
        data_next.ignore_shared = in_data.ignore_shared;
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            data_reg <= data_next;
        end
    end

endmodule

[rtl/sit_sign_stage.sv]
// Stage 3: subtract the partial products and keep the sign of each orientation.
module sit_sign_stage (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  sit_pkg::s2_t    in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output sit_pkg::s3_t    out_data
);
    import sit_pkg::*;

    logic   valid_reg;
    s3_t    data_reg;
    s3_t    data_next;
    cross_t cross_val [TURNS];

    always_comb begin
        for (int k = 0; k < TURNS; k++) begin
            cross_val[k] = CROSS_BITS'($signed(in_data.lhs[k]))
                         - CROSS_BITS'($signed(in_data.rhs[k]));
            data_next.neg[k]  = cross_val[k][CROSS_BITS-1];
            data_next.zero[k] = (cross_val[k] == '0);
        end
        data_next.use_x         = in_data.use_x;
        data_next.over_x        = in_data.over_x;
        data_next.over_y        = in_data.over_y;
        data_next.in_box        = in_data.in_box;
        data_next.shared        = in_data.shared;
        data_next.ignore_shared = in_data.ignore_shared;
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            data_reg <= data_next;
        end
    end

endmodule

[rtl/segment_intersection_test_core.sv]
// Top level of the segment intersection test: four-stage pipeline with registered result.
//
// Exact integer test of whether two segments, (first_start, first_end) and
// (second_start, second_end), intersect. One pair is accepted every clock
// cycle while the result side is not stalled; its single-bit result passes
// through the four register stages (differences, 33x33 products, product
// subtraction and sign, final decision) in that order. The result
// is 1 on a collinear overlap of positive length along the dominant axis of
// the first segment, on a proper crossing (strictly opposite orientations on
// both sides), or on a touch, where an endpoint of one segment lies on the
// other segment's line and inside its bounding box. With s_ignore_shared set,
// a touch is not counted when the segments share an endpoint; overlap and
// crossing still count. A degenerate first segment (a single point) uses the
// x axis for the overlap test. Every stage holds its transaction on a stall
// and an empty stage accepts even while later stages wait, so s_ready drops
// only when all four stages are full and m_ready is low.
module segment_intersection_test_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  sit_pkg::in_coord_t  s_first_start_x,
    input  sit_pkg::in_coord_t  s_first_start_y,
    input  sit_pkg::in_coord_t  s_first_end_x,
    input  sit_pkg::in_coord_t  s_first_end_y,
    input  sit_pkg::in_coord_t  s_second_start_x,
    input  sit_pkg::in_coord_t  s_second_start_y,
    input  sit_pkg::in_coord_t  s_second_end_x,
    input  sit_pkg::in_coord_t  s_second_end_y,
    input  logic                s_ignore_shared,
    output logic                m_valid,
    input  logic                m_ready,
    output logic                m_intersects
);
    import sit_pkg::*;

    point_t p1;
    point_t p2;
    point_t p3;
    point_t p4;

    logic s1_valid;
    logic s1_ready;
    s1_t  s1_data;
    logic s2_valid;
    logic s2_ready;
    s2_t  s2_data;
    logic s3_valid;
    logic s3_ready;
    s3_t  s3_data;

    logic out_valid_reg;
    logic intersects_reg;
    logic intersects_next;
    logic overlap;
    logic crossing;
    logic touch;

    // Bring each field to the working coordinate width, sign-extending or truncating as needed.
    assign p1.x = to_coord(s_first_start_x);
    assign p1.y = to_coord(s_first_start_y);
    assign p2.x = to_coord(s_first_end_x);
    assign p2.y = to_coord(s_first_end_y);
    assign p3.x = to_coord(s_second_start_x);
    assign p3.y = to_coord(s_second_start_y);
    assign p4.x = to_coord(s_second_end_x);
    assign p4.y = to_coord(s_second_end_y);

    sit_diff_stage u_diff (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_valid      (s_valid),
        .in_ready      (s_ready),
        .p1            (p1),
        .p2            (p2),
        .p3            (p3),
        .p4            (p4),
        .ignore_shared (s_ignore_shared),
        .out_valid     (s1_valid),
        .out_ready     (s1_ready),
        .out_data      (s1_data)
    );

    sit_mul_stage u_mul (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s1_valid),
        .in_ready  (s1_ready),
        .in_data   (s1_data),
        .out_valid (s2_valid),
        .out_ready (s2_ready),
        .out_data  (s2_data)
    );

    sit_sign_stage u_sign (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s2_valid),
        .in_ready  (s2_ready),
        .in_data   (s2_data),
        .out_valid (s3_valid),
        .out_ready (s3_ready),
        .out_data  (s3_data)
    );

    // Final decision. Orientation order: turn of second start and second end
    // against the first segment, then first start and first end against the second.
    always_comb begin
        overlap  = s3_data.zero[0] && s3_data.zero[1]
                && (s3_data.use_x ? s3_data.over_x : s3_data.over_y);
        crossing = !s3_data.zero[0] && !s3_data.zero[1]
                && (s3_data.neg[0] != s3_data.neg[1])
                && !s3_data.zero[2] && !s3_data.zero[3]
                && (s3_data.neg[2] != s3_data.neg[3]);
        touch    = |(s3_data.zero & s3_data.in_box);
        // Drop a touch at a shared endpoint when asked to.
        intersects_next = overlap || crossing
                       || (touch && !(s3_data.ignore_shared && s3_data.shared));
    end

    // Output register: hold the result until the sink takes it.
    assign s3_ready     = !out_valid_reg || m_ready;
    assign m_valid      = out_valid_reg;
    assign m_intersects = intersects_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (s3_ready) begin
            out_valid_reg <= s3_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s3_valid && s3_ready) begin
            intersects_reg <= intersects_next;
        end
    end

    // Backpressure reaches the input only with every stage occupied.
    a_full_when_blocked: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (s1_valid && s2_valid && s3_valid && out_valid_reg))
        else $error("input blocked while a pipeline stage is empty");

    // With the sink ready throughout, an accepted transaction passes the stages without a stall and reaches the output.
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && m_ready) ##1 m_ready ##1 m_ready ##1 m_ready |=> m_valid)
        else $error("transaction did not reach the output on time");

    // A stalled sign stage holds its transaction.
    a_sign_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (s3_valid && !s3_ready) |=> (s3_valid && $stable(s3_data)))
        else $error("sign stage lost its transaction under a stall");

endmodule

[verif/segment_intersection_test_core_test.sv]
// Self-checking testbench for the segment intersection test core: random and directed segment pairs.
module segment_intersection_test_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    // One segment pair as it goes onto the input channel.
    typedef struct packed {
        sit_pkg::in_coord_t fsx;
        sit_pkg::in_coord_t fsy;
        sit_pkg::in_coord_t fex;
        sit_pkg::in_coord_t fey;
        sit_pkg::in_coord_t ssx;
        sit_pkg::in_coord_t ssy;
        sit_pkg::in_coord_t sex;
        sit_pkg::in_coord_t sey;
        logic               ign;
    } seg_pair_t;

    // A point on the grid, widened so that differences never wrap.
    typedef struct {
        longint x;
        longint y;
    } grid_pt_t;

    // How the result side paces its ready.
    typedef enum int {
        RDY_ALWAYS,
        RDY_PATTERN,
        RDY_SPARSE,
        RDY_COIN
    } rdy_mode_t;

    localparam sit_pkg::in_coord_t CMIN = 32'sh8000_0000;
    localparam sit_pkg::in_coord_t CMAX = 32'sh7fff_ffff;
    localparam int RANDOM_PAIRS = 1080;
    localparam int DRAIN_AT_A   = 350;
    localparam int DRAIN_AT_B   = 800;
    localparam int TAIL_CYCLES  = 16;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    sit_pkg::in_coord_t s_first_start_x = '0;
    sit_pkg::in_coord_t s_first_start_y = '0;
    sit_pkg::in_coord_t s_first_end_x = '0;
    sit_pkg::in_coord_t s_first_end_y = '0;
    sit_pkg::in_coord_t s_second_start_x = '0;
    sit_pkg::in_coord_t s_second_start_y = '0;
    sit_pkg::in_coord_t s_second_end_x = '0;
    sit_pkg::in_coord_t s_second_end_y = '0;
    logic               s_ignore_shared = 1'b0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic               m_intersects;

    // Pairs waiting to be sent, and the verdicts owed by the block in order.
    seg_pair_t pending_q[$];
    bit        intersect_expect_q[$];

    int accepted_total = 0;   // driver side, transactions taken by the block
    int results_seen = 0;     // monitor side, updated with NBA so the driver reads it cleanly
    int mismatch_count = 0;
    int directed_pairs = 0;
    int shared_rule_pairs = 0;
    int hits_seen = 0;

    segment_intersection_test_core dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_first_start_x  (s_first_start_x),
        .s_first_start_y  (s_first_start_y),
        .s_first_end_x    (s_first_end_x),
        .s_first_end_y    (s_first_end_y),
        .s_second_start_x (s_second_start_x),
        .s_second_start_y (s_second_start_y),
        .s_second_end_x   (s_second_end_x),
        .s_second_end_y   (s_second_end_y),
        .s_ignore_shared  (s_ignore_shared),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_intersects     (m_intersects)
    );

    always #2 aclk = ~aclk;

    // ------------------------------------------------------------------
    // Predictor: exact integer geometry on 128-bit cross products.
    // ------------------------------------------------------------------

    // Take the low COORD_BITS of a port value and sign-extend them.
    function automatic longint to_grid(sit_pkg::in_coord_t raw);
        longint v;
        v = longint'(raw);
        v = v <<< (64 - sit_pkg::COORD_BITS);
        return v >>> (64 - sit_pkg::COORD_BITS);
    endfunction

    function automatic longint lmin(longint a, longint b);
        return (a < b) ? a : b;
    endfunction

    function automatic longint lmax(longint a, longint b);
        return (a > b) ? a : b;
    endfunction

    // Sign of cross(b - a, c - a).
    function automatic int turn_dir(grid_pt_t a, grid_pt_t b, grid_pt_t c);
        logic signed [127:0] ux, uy, vx, vy, cr;
        ux = b.x - a.x;
        uy = b.y - a.y;
        vx = c.x - a.x;
        vy = c.y - a.y;
        cr = ux * vy - uy * vx;
        if (cr == 0) return 0;
        return (cr < 0) ? -1 : 1;
    endfunction

    // Point p on the line through a and b and inside their bounding box.
    function automatic bit on_segment_box(grid_pt_t a, grid_pt_t b, grid_pt_t p);
        if (turn_dir(a, b, p) != 0) return 1'b0;
        return p.x >= lmin(a.x, b.x) && p.x <= lmax(a.x, b.x) &&
               p.y >= lmin(a.y, b.y) && p.y <= lmax(a.y, b.y);
    endfunction

    // Collinear overlap of positive length, measured on the first segment's dominant axis.
    function automatic bit collinear_overlap(grid_pt_t a, grid_pt_t b, grid_pt_t c, grid_pt_t d);
        longint span_x, span_y, a0, a1, c0, c1;
        bit     along_x;
        if (turn_dir(a, b, c) != 0 || turn_dir(a, b, d) != 0) return 1'b0;
        span_x = b.x - a.x;
        span_y = b.y - a.y;
        if (span_x < 0) span_x = -span_x;
        if (span_y < 0) span_y = -span_y;
        along_x = span_x >= span_y;
        a0 = along_x ? a.x : a.y;
        a1 = along_x ? b.x : b.y;
        c0 = along_x ? c.x : c.y;
        c1 = along_x ? d.x : d.y;
        return lmin(lmax(a0, a1), lmax(c0, c1)) > lmax(lmin(a0, a1), lmin(c0, c1));
    endfunction

    function automatic bit same_point(grid_pt_t a, grid_pt_t b);
        return a.x == b.x && a.y == b.y;
    endfunction

    function automatic bit predict_intersects(seg_pair_t s);
        grid_pt_t p1, p2, p3, p4;
        int       o1, o2, o3, o4;
        bit       shared, touch;
        p1.x = to_grid(s.fsx); p1.y = to_grid(s.fsy);
        p2.x = to_grid(s.fex); p2.y = to_grid(s.fey);
        p3.x = to_grid(s.ssx); p3.y = to_grid(s.ssy);
        p4.x = to_grid(s.sex); p4.y = to_grid(s.sey);
        shared = same_point(p1, p3) || same_point(p1, p4) ||
                 same_point(p2, p3) || same_point(p2, p4);
        if (collinear_overlap(p1, p2, p3, p4)) return 1'b1;
        o1 = turn_dir(p1, p2, p3);
        o2 = turn_dir(p1, p2, p4);
        o3 = turn_dir(p3, p4, p1);
        o4 = turn_dir(p3, p4, p2);
        // Proper crossing: strictly opposite sides, both ways round.
        if (o1 * o2 < 0 && o3 * o4 < 0) return 1'b1;
        touch = (o1 == 0 && on_segment_box(p1, p2, p3)) ||
                (o2 == 0 && on_segment_box(p1, p2, p4)) ||
                (o3 == 0 && on_segment_box(p3, p4, p1)) ||
                (o4 == 0 && on_segment_box(p3, p4, p2));
        // The shared-endpoint rule only ever drops a touch.
        return touch && !(s.ign && shared);
    endfunction

    // ------------------------------------------------------------------
    // Stimulus generation.
    // ------------------------------------------------------------------

    function automatic seg_pair_t mk_pair(sit_pkg::in_coord_t a, sit_pkg::in_coord_t b,
                                          sit_pkg::in_coord_t c, sit_pkg::in_coord_t d,
                                          sit_pkg::in_coord_t e, sit_pkg::in_coord_t f,
                                          sit_pkg::in_coord_t g, sit_pkg::in_coord_t h,
                                          logic ign);
        seg_pair_t s;
        s = '{fsx: a, fsy: b, fex: c, fey: d, ssx: e, ssy: f, sex: g, sey: h, ign: ign};
        return s;
    endfunction

    // Append a pair to the send queue.
    function automatic void add_pending(seg_pair_t s);
        pending_q = {pending_q, s};
    endfunction

    function automatic sit_pkg::in_coord_t small_off(int r);
        return sit_pkg::in_coord_t'(int'($urandom_range(0, 2 * r)) - r);
    endfunction

    // Either near the origin or anywhere on the grid.
    function automatic sit_pkg::in_coord_t base_coord();
        if ($urandom_range(0, 1) == 0) return small_off(20);
        return sit_pkg::in_coord_t'($urandom);
    endfunction

    function automatic sit_pkg::in_coord_t edge_coord();
        case ($urandom_range(0, 7))
            0: return CMIN;
            1: return CMAX;
            2: return '0;
            3: return -1;
            4: return 1;
            5: return CMIN + 1;
            6: return CMAX - 1;
            default: return sit_pkg::in_coord_t'($urandom);
        endcase
    endfunction

    function automatic seg_pair_t gen_pair();
        sit_pkg::in_coord_t c [8];
        sit_pkg::in_coord_t t [8];
        sit_pkg::in_coord_t bx, by, dx, dy;
        int                 k, j, a, b;
        case ($urandom_range(0, 9))
            0: begin
                // Fully random coordinates: exercise every bit.
                for (int i = 0; i < 8; i++) c[i] = sit_pkg::in_coord_t'($urandom);
            end
            1: begin
                for (int i = 0; i < 8; i++) c[i] = edge_coord();
            end
            2, 3: begin
                // Tiny grid: lots of collinear, touching and shared cases.
                for (int i = 0; i < 8; i++) c[i] = small_off(6);
            end
            4, 5: begin
                // All four points on one line, sometimes nudged off it.
                bx = base_coord();
                by = base_coord();
                dx = small_off(3);
                dy = small_off(3);
                for (int i = 0; i < 4; i++) begin
                    k = int'($urandom_range(0, 8)) - 4;
                    c[2 * i]     = bx + sit_pkg::in_coord_t'(k) * dx;
                    c[2 * i + 1] = by + sit_pkg::in_coord_t'(k) * dy;
                end
                if ($urandom_range(0, 3) == 0) begin
                    j = $urandom_range(0, 7);
                    c[j] = c[j] + (($urandom_range(0, 1) == 0) ? 1 : -1);
                end
            end
            6: begin
                // Copy one endpoint of the first segment onto the second.
                for (int i = 0; i < 8; i++) c[i] = ($urandom_range(0, 1) == 0) ? small_off(8)
                                                                            : base_coord();
                a = $urandom_range(0, 1);
                b = $urandom_range(2, 3);
                c[2 * b]     = c[2 * a];
                c[2 * b + 1] = c[2 * a + 1];
            end
            7: begin
                // T junction: the second segment starts on the first one.
                bx = base_coord();
                by = base_coord();
                dx = small_off(3);
                dy = small_off(3);
                k = $urandom_range(1, 4);
                j = $urandom_range(0, k);
                c[0] = bx;
                c[1] = by;
                c[2] = bx + sit_pkg::in_coord_t'(k) * dx;
                c[3] = by + sit_pkg::in_coord_t'(k) * dy;
                c[4] = bx + sit_pkg::in_coord_t'(j) * dx;
                c[5] = by + sit_pkg::in_coord_t'(j) * dy;
                c[6] = c[4] + small_off(5);
                c[7] = c[5] + small_off(5);
            end
            8: begin
                // Two segments through a common center: crossings at large coordinates.
                bx = sit_pkg::in_coord_t'($urandom);
                by = sit_pkg::in_coord_t'($urandom);
                dx = small_off(1 << 20);
                dy = small_off(1 << 20);
                c[0] = bx - dx;
                c[1] = by - dy;
                c[2] = bx + dx;
                c[3] = by + dy;
                dx = small_off(1 << 20);
                dy = small_off(1 << 20);
                c[4] = bx - dx;
                c[5] = by - dy;
                c[6] = bx + 2 * dx;
                c[7] = by + 2 * dy;
            end
            default: begin
                // One segment shrunk to a point.
                for (int i = 0; i < 8; i++) c[i] = small_off(6);
                if ($urandom_range(0, 1) == 0) begin
                    c[2] = c[0];
                    c[3] = c[1];
                end else begin
                    c[6] = c[4];
                    c[7] = c[5];
                end
            end
        endcase
        // Swap segment roles half the time: the dominant axis follows the first one.
        if ($urandom_range(0, 1) == 0) begin
            for (int i = 0; i < 4; i++) t[i] = c[i + 4];
            for (int i = 0; i < 4; i++) t[i + 4] = c[i];
            for (int i = 0; i < 8; i++) c[i] = t[i];
        end
        return mk_pair(c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7],
                       logic'($urandom_range(0, 1)));
    endfunction

    // ------------------------------------------------------------------
    // Driver: bursts of transactions with random gaps, two full drains.
    // ------------------------------------------------------------------
    seg_pair_t cur_pair;
    int        burst_left = 1;
    int        gap_left = 0;
    bit        drain_hold = 1'b0;

    always @(posedge aclk) begin
        bit fire;
        bit show;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            fire = s_valid && s_ready;
            // Hold a presented pair until the block takes it.
            show = s_valid && !fire;
            if (fire) begin
                intersect_expect_q = {intersect_expect_q, predict_intersects(cur_pair)};
                accepted_total++;
                if (cur_pair.ign) shared_rule_pairs++;
                // Stop sending and let the pipeline empty at these points.
                if (accepted_total == DRAIN_AT_A || accepted_total == DRAIN_AT_B) begin
                    drain_hold = 1'b1;
                end
            end
            if (!show) begin
                if (drain_hold) begin
                    if (accepted_total == results_seen) drain_hold = 1'b0;
                end else if (gap_left > 0) begin
                    gap_left--;
                end else if (pending_q.size() > 0) begin
                    cur_pair = pending_q.pop_front();
                    show = 1'b1;
                    s_first_start_x  <= cur_pair.fsx;
                    s_first_start_y  <= cur_pair.fsy;
                    s_first_end_x    <= cur_pair.fex;
                    s_first_end_y    <= cur_pair.fey;
                    s_second_start_x <= cur_pair.ssx;
                    s_second_start_y <= cur_pair.ssy;
                    s_second_end_x   <= cur_pair.sex;
                    s_second_end_y   <= cur_pair.sey;
                    s_ignore_shared  <= cur_pair.ign;
                    // Advance the burst; at its end pick the next burst and gap.
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 32);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
                    end
                end
            end
            s_valid <= show;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: pace ready, compare each result with the oldest verdict.
    // ------------------------------------------------------------------
    rdy_mode_t   rdy_mode = RDY_ALWAYS;
    int          rdy_left = 0;
    logic [15:0] rdy_pat = '1;
    logic [3:0]  rdy_phase = '0;

    always @(posedge aclk) begin
        bit want;
        bit rdy;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (intersect_expect_q.size() == 0) begin
                    if (mismatch_count < 10) begin
                        $display("ERROR: result %0d arrived with nothing expected (got %0b)",
                                 results_seen, m_intersects);
                    end
                    mismatch_count++;
                end else begin
                    want = intersect_expect_q.pop_front();
                    if (m_intersects !== want) begin
                        if (mismatch_count < 10) begin
                            $display("ERROR: result %0d intersects expected %0b, got %0b",
                                     results_seen, want, m_intersects);
                        end
                        mismatch_count++;
                    end
                end
                if (m_intersects === 1'b1) hits_seen++;
                results_seen <= results_seen + 1;
            end
            // Switch to a new random ready pattern when the current one runs out.
            if (rdy_left == 0) begin
                rdy_mode = rdy_mode_t'($urandom_range(0, 3));
                rdy_left = $urandom_range(16, 96);
                rdy_pat = 16'($urandom) | (16'h1 << $urandom_range(0, 15));
            end
            rdy_left--;
            case (rdy_mode)
                RDY_ALWAYS:  rdy = 1'b1;
                RDY_PATTERN: rdy = rdy_pat[rdy_phase];
                RDY_SPARSE:  rdy = ($urandom_range(0, 3) == 0);
                default:     rdy = ($urandom_range(0, 1) == 1);
            endcase
            rdy_phase <= rdy_phase + 4'd1;
            m_ready <= rdy;
        end
    end

    // ------------------------------------------------------------------
    // Sequence: fill the queue, reset, wait for the last result, report.
    // ------------------------------------------------------------------
    initial begin
        // All four points coincide: a touch, dropped under the shared rule.
        add_pending(mk_pair(0, 0, 0, 0, 0, 0, 0, 0, 1'b0));
        add_pending(mk_pair(0, 0, 0, 0, 0, 0, 0, 0, 1'b1));
        // Plain crossing and parallel miss.
        add_pending(mk_pair(0, 0, 4, 4, 0, 4, 4, 0, 1'b0));
        add_pending(mk_pair(0, 0, 4, 0, 0, 1, 4, 1, 1'b0));
        // Collinear overlap along x, touch at one endpoint, overlap with shared endpoint.
        add_pending(mk_pair(0, 0, 4, 0, 2, 0, 6, 0, 1'b1));
        add_pending(mk_pair(0, 0, 2, 0, 2, 0, 5, 0, 1'b0));
        add_pending(mk_pair(0, 0, 2, 0, 2, 0, 5, 0, 1'b1));
        add_pending(mk_pair(0, 0, 4, 0, 0, 0, 2, 0, 1'b1));
        // Vertical overlap uses the y axis; collinear gap misses.
        add_pending(mk_pair(0, 0, 0, 8, 0, 3, 0, 10, 1'b0));
        add_pending(mk_pair(0, 0, 1, 0, 3, 0, 5, 0, 1'b0));
        // T junction with no shared endpoint survives the shared rule.
        add_pending(mk_pair(0, 0, 4, 0, 2, 0, 2, 5, 1'b1));
        // Degenerate first segment: on the second, and off it with x-axis overlap test.
        add_pending(mk_pair(1, 1, 1, 1, 0, 0, 2, 2, 1'b0));
        add_pending(mk_pair(1, 1, 1, 1, 0, 5, 3, -2, 1'b0));
        // Degenerate second segment off the first.
        add_pending(mk_pair(0, 0, 6, 6, 3, 4, 3, 4, 1'b0));
        // Grid corners: widest products.
        add_pending(mk_pair(CMIN, CMIN, CMAX, CMAX, CMIN, CMAX, CMAX, CMIN, 1'b0));
        add_pending(mk_pair(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, 1'b0));
        add_pending(mk_pair(CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, 1'b1));
        add_pending(mk_pair(CMIN, CMAX, CMAX, CMIN, CMIN, CMIN, CMIN, CMAX, 1'b1));
        add_pending(mk_pair(CMIN, CMAX, CMAX, CMIN, CMIN, CMIN, CMIN, CMAX, 1'b0));
        // Almost collinear at full scale, then a near miss past an endpoint.
        add_pending(mk_pair(CMIN, CMIN, CMAX, CMAX - 1, 0, 0, 1, 1, 1'b0));
        add_pending(mk_pair(0, 0, 4, 4, 5, 5, 6, 0, 1'b0));
        // Alternating bit patterns.
        add_pending(mk_pair(32'sh5555_5555, 32'shAAAA_AAAA, 32'shAAAA_AAAA,
                            32'sh5555_5555, 32'shAAAA_AAAA, 32'shAAAA_AAAA,
                            32'sh5555_5555, 32'sh5555_5555, 1'b1));
        directed_pairs = pending_q.size();
        for (int i = 0; i < RANDOM_PAIRS; i++) add_pending(gen_pair());

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // Sample on the falling edge so the clocked blocks have settled.
        do @(negedge aclk);
        while (pending_q.size() != 0 || s_valid || accepted_total != results_seen);
        repeat (TAIL_CYCLES) @(negedge aclk);

        if (intersect_expect_q.size() != 0) begin
            $display("ERROR: %0d results never arrived", intersect_expect_q.size());
            mismatch_count += intersect_expect_q.size();
        end
        $display("Covered %0d segment pairs (%0d directed, %0d under the shared-endpoint rule)",
                 accepted_total, directed_pairs, shared_rule_pairs);
        $display("Checked %0d results: %0d intersecting, %0d apart; %0d mismatches",
                 results_seen, hits_seen, results_seen - hits_seen, mismatch_count);
        if (mismatch_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #2_000_000;
        $display("ERROR: timeout with %0d of %0d results in", results_seen, accepted_total);
        $display("Some tests failed");
        $finish;
    end

endmodule
